### rtl/qrs_pkg.sv
package qrs_pkg;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_INDET      = 3'd0;
   localparam kind_type KIND_IMPOSSIBLE = 3'd1;
   localparam kind_type KIND_LINEAR     = 3'd2;
   localparam kind_type KIND_DOUBLE     = 3'd3;
   localparam kind_type KIND_DISTINCT   = 3'd4;
   localparam kind_type KIND_COMPLEX    = 3'd5;

endpackage

### rtl/qrs_sqrt_cell.sv
module qrs_sqrt_cell #(
   parameter int XE     = 50,
   parameter int SW     = 25,
   parameter int SIDE_W = 51
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_i,
   input  logic [XE-1:0]     x_i,
   input  logic [SW+1:0]     rem_i,
   input  logic [SW-1:0]     root_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              valid_o,
   output logic [XE-1:0]     x_o,
   output logic [SW+1:0]     rem_o,
   output logic [SW-1:0]     root_o,
   output logic [SIDE_W-1:0] side_o
);

   localparam int REMW = SW + 2;

   logic [REMW-1:0]   cur;
   logic [REMW-1:0]   trial;
   logic              fits;
   logic              valid_ff;
   logic [XE-1:0]     x_ff, x_in;
   logic [REMW-1:0]   rem_ff, rem_in;
   logic [SW-1:0]     root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;

   assign cur     = {rem_i[REMW-3:0], x_i[XE-1 -: 2]};
   assign trial   = {root_i, 2'b01};
   assign fits    = (cur >= trial);
   assign rem_in  = fits ? (cur - trial) : cur;
   assign root_in = {root_i[SW-2:0], fits};
   assign x_in    = {x_i[XE-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= side_i;
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign side_o  = side_ff;

endmodule

### rtl/qrs_div_cell.sv
module qrs_div_cell #(
   parameter int NW     = 35,
   parameter int DENW   = 17,
   parameter int SIDE_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_i,
   input  logic [NW-1:0]     nq_i,
   input  logic [DENW-1:0]   rem_i,
   input  logic [DENW-1:0]   den_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              valid_o,
   output logic [NW-1:0]     nq_o,
   output logic [DENW-1:0]   rem_o,
   output logic [DENW-1:0]   den_o,
   output logic [SIDE_W-1:0] side_o
);

   logic [DENW:0]     cur;
   logic [DENW:0]     diff;
   logic              fits;
   logic              valid_ff;
   logic [NW-1:0]     nq_ff, nq_in;
   logic [DENW-1:0]   rem_ff, rem_in;
   logic [DENW-1:0]   den_ff;
   logic [SIDE_W-1:0] side_ff;

   assign cur    = {rem_i, nq_i[NW-1]};
   assign diff   = cur - {1'b0, den_i};
   assign fits   = (cur >= {1'b0, den_i});
   assign rem_in = fits ? diff[DENW-1:0] : cur[DENW-1:0];
   assign nq_in  = {nq_i[NW-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff   <= nq_in;
      rem_ff  <= rem_in;
      den_ff  <= den_i;
      side_ff <= side_i;
   end

   assign valid_o = valid_ff;
   assign nq_o    = nq_ff;
   assign rem_o   = rem_ff;
   assign den_o   = den_ff;
   assign side_o  = side_ff;

endmodule

### rtl/quadratic_root_solver.sv
// Quadratic equation solver: classifies a*x^2 + b*x + c = 0 and returns its roots.
// Request channel: coefficients on req_coef_a/b/c, transferred at a rising edge
// with start high and busy low. busy is always low, so a new coefficient set may
// be given in every cycle.
// Response channel: rsp_valid is high for one cycle with rsp_root_kind,
// rsp_first_root, rsp_second_root and rsp_saturated; the receiver cannot stall,
// each result is taken in the cycle it is shown.
// Two stages form the discriminant, a row of
// SW square-root cells (one root bit each), one stage forms the numerators, a
// row of NMW divider cells (one quotient bit each, two lanes), and one stage
// negates and clamps. With the default parameters SW = 25 and NMW = 35.
// Throughput is one set per cycle; results leave in request order.
// Reset clears all valid bits in the pipeline; sets in flight are dropped.
module quadratic_root_solver #(
   parameter int COEF_WIDTH     = 16,
   parameter int COEF_FRAC_BITS = 8,
   parameter int ROOT_WIDTH     = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COEF_WIDTH-1:0] req_coef_a,
   input  logic signed [COEF_WIDTH-1:0] req_coef_b,
   input  logic signed [COEF_WIDTH-1:0] req_coef_c,
   output logic                         rsp_valid,
   output qrs_pkg::kind_type            rsp_root_kind,
   output logic signed [ROOT_WIDTH-1:0] rsp_first_root,
   output logic signed [ROOT_WIDTH-1:0] rsp_second_root,
   output logic                         rsp_saturated
);

   import qrs_pkg::*;

   localparam int CW   = COEF_WIDTH;
   localparam int F    = COEF_FRAC_BITS;
   localparam int RW   = ROOT_WIDTH;
   localparam int RF   = ROOT_WIDTH / 2;
   localparam int DW   = 2 * CW + 2;
   localparam int MW   = 2 * CW + 1;
   localparam int SH   = 2 * RF - 2 * F;
   localparam int XW   = MW + SH;
   localparam int XE   = XW + (XW % 2);
   localparam int SW   = XE / 2;
   localparam int NQA  = CW + RF - F - 1;
   localparam int NQB  = (NQA > SW) ? NQA : SW;
   localparam int NQ   = NQB + 1 + F;
   localparam int NMW  = (((CW + RF) > NQ) ? (CW + RF) : NQ) + 1;
   localparam int WW   = NMW + 2;
   localparam int DMW  = CW + 1;
   localparam int QW   = ((NMW > RW) ? NMW : RW) + 1;
   localparam int SQ_SIDE = 3 + 3 * CW;

   localparam logic [QW-1:0] HI_MAG = (QW'(1) << (RW - 1)) - QW'(1);
   localparam logic [QW-1:0] LO_MAG = QW'(1) << (RW - 1);

   function automatic logic [RW:0] clamp(input logic [NMW-1:0] q, input logic neg);
      logic [QW-1:0] qx;
      logic [QW-1:0] qn;
      logic [RW:0]   res;
      qx = QW'(q);
      qn = -qx;
      if (neg) begin
         if (qx > LO_MAG) res = {1'b1, LO_MAG[RW-1:0]};
         else             res = {1'b0, qn[RW-1:0]};
      end else begin
         if (qx > HI_MAG) res = {1'b1, HI_MAG[RW-1:0]};
         else             res = {1'b0, qx[RW-1:0]};
      end
      return res;
   endfunction

   // stage 1: products
   logic                   s1_valid_ff;
   logic signed [CW-1:0]   s1_a_ff, s1_b_ff, s1_c_ff;
   logic signed [2*CW-1:0] s1_bb_ff, s1_ac_ff, s1_bb_in, s1_ac_in;

   assign busy     = 1'b0;
   assign s1_bb_in = req_coef_b * req_coef_b;
   assign s1_ac_in = req_coef_a * req_coef_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_a_ff  <= req_coef_a;
      s1_b_ff  <= req_coef_b;
      s1_c_ff  <= req_coef_c;
      s1_bb_ff <= s1_bb_in;
      s1_ac_ff <= s1_ac_in;
   end

   // stage 2: discriminant and class
   logic signed [DW-1:0]  disc;
   logic signed [DW-1:0]  disc_abs;
   logic [MW-1:0]         disc_mag;
   kind_type              s2_kind_in, s2_kind_ff;
   logic                  s2_valid_ff;
   logic [XE-1:0]         s2_x_ff, s2_x_in;
   logic signed [CW-1:0]  s2_a_ff, s2_b_ff, s2_c_ff;

   assign disc     = DW'(s1_bb_ff) - (DW'(s1_ac_ff) <<< 2);
   assign disc_abs = disc[DW-1] ? -disc : disc;
   assign disc_mag = disc_abs[MW-1:0];
   assign s2_x_in  = XE'(disc_mag) << SH;

   always_comb begin
      priority if (s1_a_ff == '0) begin
         priority if (s1_b_ff != '0) s2_kind_in = KIND_LINEAR;
         else if (s1_c_ff != '0)     s2_kind_in = KIND_IMPOSSIBLE;
         else                        s2_kind_in = KIND_INDET;
      end else if (disc == '0) begin
         s2_kind_in = KIND_DOUBLE;
      end else if (disc[DW-1]) begin
         s2_kind_in = KIND_COMPLEX;
      end else begin
         s2_kind_in = KIND_DISTINCT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_kind_ff <= s2_kind_in;
      s2_x_ff    <= s2_x_in;
      s2_a_ff    <= s1_a_ff;
      s2_b_ff    <= s1_b_ff;
      s2_c_ff    <= s1_c_ff;
   end

   // square-root row
   logic               sq_valid [0:SW];
   logic [XE-1:0]      sq_x     [0:SW];
   logic [SW+1:0]      sq_rem   [0:SW];
   logic [SW-1:0]      sq_root  [0:SW];
   logic [SQ_SIDE-1:0] sq_side  [0:SW];

   assign sq_valid[0] = s2_valid_ff;
   assign sq_x[0]     = s2_x_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = {s2_kind_ff, s2_a_ff, s2_b_ff, s2_c_ff};

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.XE(XE), .SW(SW), .SIDE_W(SQ_SIDE)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (sq_valid[i]),
         .x_i     (sq_x[i]),
         .rem_i   (sq_rem[i]),
         .root_i  (sq_root[i]),
         .side_i  (sq_side[i]),
         .valid_o (sq_valid[i+1]),
         .x_o     (sq_x[i+1]),
         .rem_o   (sq_rem[i+1]),
         .root_o  (sq_root[i+1]),
         .side_o  (sq_side[i+1])
      );
   end

   // stage 3: numerators and denominators
   kind_type             k3;
   logic signed [CW-1:0] a3, b3, c3;
   logic signed [WW-1:0] nbw, sw, num0, num1, abs0, abs1;
   logic signed [CW+1:0] twoa, den0, den1, dabs0, dabs1;
   logic                 s3_valid_ff;
   logic [NMW-1:0]       s3_n0_ff, s3_n1_ff;
   logic [DMW-1:0]       s3_d0_ff, s3_d1_ff;
   logic [3:0]           s3_side0_ff;
   logic                 s3_side1_ff;

   assign {k3, a3, b3, c3} = sq_side[SW];
   assign nbw  = -(WW'(b3)) <<< (RF - F);
   assign sw   = signed'(WW'(sq_root[SW]));
   assign twoa = (CW + 2)'(a3) <<< 1;

   always_comb begin
      unique case (k3)
         KIND_LINEAR: begin
            num0 = -(WW'(c3)) <<< RF;
            den0 = (CW + 2)'(b3);
            num1 = '0;
            den1 = (CW + 2)'(1);
         end
         KIND_DOUBLE: begin
            num0 = nbw <<< F;
            den0 = twoa;
            num1 = nbw <<< F;
            den1 = twoa;
         end
         KIND_DISTINCT: begin
            num0 = (nbw - sw) <<< F;
            den0 = twoa;
            num1 = (nbw + sw) <<< F;
            den1 = twoa;
         end
         KIND_COMPLEX: begin
            num0 = nbw <<< F;
            den0 = twoa;
            num1 = sw <<< F;
            den1 = twoa;
         end
         default: begin
            num0 = '0;
            den0 = (CW + 2)'(1);
            num1 = '0;
            den1 = (CW + 2)'(1);
         end
      endcase
   end

   assign abs0  = num0[WW-1] ? -num0 : num0;
   assign abs1  = num1[WW-1] ? -num1 : num1;
   assign dabs0 = den0[CW+1] ? -den0 : den0;
   assign dabs1 = den1[CW+1] ? -den1 : den1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= sq_valid[SW];
      end
   end

   always_ff @(posedge clock) begin
      s3_n0_ff    <= abs0[NMW-1:0];
      s3_n1_ff    <= abs1[NMW-1:0];
      s3_d0_ff    <= dabs0[DMW-1:0];
      s3_d1_ff    <= dabs1[DMW-1:0];
      s3_side0_ff <= {k3, num0[WW-1] ^ den0[CW+1]};
      s3_side1_ff <= num1[WW-1] ^ den1[CW+1];
   end

   // divider rows
   logic           d0_valid [0:NMW];
   logic [NMW-1:0] d0_nq    [0:NMW];
   logic [DMW-1:0] d0_rem   [0:NMW];
   logic [DMW-1:0] d0_den   [0:NMW];
   logic [3:0]     d0_side  [0:NMW];
   logic           d1_valid [0:NMW];
   logic [NMW-1:0] d1_nq    [0:NMW];
   logic [DMW-1:0] d1_rem   [0:NMW];
   logic [DMW-1:0] d1_den   [0:NMW];
   logic           d1_side  [0:NMW];

   assign d0_valid[0] = s3_valid_ff;
   assign d0_nq[0]    = s3_n0_ff;
   assign d0_rem[0]   = '0;
   assign d0_den[0]   = s3_d0_ff;
   assign d0_side[0]  = s3_side0_ff;
   assign d1_valid[0] = s3_valid_ff;
   assign d1_nq[0]    = s3_n1_ff;
   assign d1_rem[0]   = '0;
   assign d1_den[0]   = s3_d1_ff;
   assign d1_side[0]  = s3_side1_ff;

   for (genvar i = 0; i < NMW; i++) begin : g_div
      qrs_div_cell #(.NW(NMW), .DENW(DMW), .SIDE_W(4)) u_lane0 (
         .clock   (clock),
         .reset   (reset),
         .valid_i (d0_valid[i]),
         .nq_i    (d0_nq[i]),
         .rem_i   (d0_rem[i]),
         .den_i   (d0_den[i]),
         .side_i  (d0_side[i]),
         .valid_o (d0_valid[i+1]),
         .nq_o    (d0_nq[i+1]),
         .rem_o   (d0_rem[i+1]),
         .den_o   (d0_den[i+1]),
         .side_o  (d0_side[i+1])
      );
      qrs_div_cell #(.NW(NMW), .DENW(DMW), .SIDE_W(1)) u_lane1 (
         .clock   (clock),
         .reset   (reset),
         .valid_i (d1_valid[i]),
         .nq_i    (d1_nq[i]),
         .rem_i   (d1_rem[i]),
         .den_i   (d1_den[i]),
         .side_i  (d1_side[i]),
         .valid_o (d1_valid[i+1]),
         .nq_o    (d1_nq[i+1]),
         .rem_o   (d1_rem[i+1]),
         .den_o   (d1_den[i+1]),
         .side_o  (d1_side[i+1])
      );
   end

   // output stage: sign, clamp
   logic [RW:0]   r0_in, r1_in;
   logic          out_valid_ff;
   kind_type      out_kind_ff;
   logic [RW-1:0] out_r0_ff, out_r1_ff;
   logic          out_sat_ff;

   assign r0_in = clamp(d0_nq[NMW], d0_side[NMW][0]);
   assign r1_in = clamp(d1_nq[NMW], d1_side[NMW]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= d0_valid[NMW];
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= d0_side[NMW][3:1];
      out_r0_ff   <= r0_in[RW-1:0];
      out_r1_ff   <= r1_in[RW-1:0];
      out_sat_ff  <= r0_in[RW] | r1_in[RW];
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_root_kind   = out_kind_ff;
   assign rsp_first_root  = signed'(out_r0_ff);
   assign rsp_second_root = signed'(out_r1_ff);
   assign rsp_saturated   = out_sat_ff;

endmodule

### tb/sv/tb.sv
module tb;
   import qrs_pkg::*;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
   } coef_set_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] r0;
      logic signed [31:0] r1;
      logic               sat;
   } root_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_coef_a = '0;
   logic signed [15:0] req_coef_b = '0;
   logic signed [15:0] req_coef_c = '0;
   logic rsp_valid;
   kind_type rsp_root_kind;
   logic signed [31:0] rsp_first_root;
   logic signed [31:0] rsp_second_root;
   logic rsp_saturated;

   coef_set_type pending_sets[$];
   root_set_type expected_roots[$];
   int        send_idle_pct = 0;
   bit        hold_sender = 1'b0;
   int        error_count = 0;
   int        transfer_count = 0;
   int        kind_seen[6];
   int        sat_seen = 0;

   quadratic_root_solver u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_coef_c(req_coef_c),
      .rsp_valid(rsp_valid), .rsp_root_kind(rsp_root_kind),
      .rsp_first_root(rsp_first_root), .rsp_second_root(rsp_second_root),
      .rsp_saturated(rsp_saturated)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] divide_clamp(longint num, longint den,
                                                       inout logic sat);
      longint q;
      q = num / den;
      if (q > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (q < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return q[31:0];
   endfunction

   function automatic root_set_type solve_quadratic(coef_set_type cs);
      root_set_type r;
      longint a, b, c, disc, two_a, nb, s;
      longint unsigned mag;
      a = cs.a;
      b = cs.b;
      c = cs.c;
      r = '0;
      if (a == 0) begin
         if (b == 0) begin
            r.kind = (c == 0) ? KIND_INDET : KIND_IMPOSSIBLE;
         end else begin
            r.kind = KIND_LINEAR;
            r.r0 = divide_clamp(-c * 65536, b, r.sat);
         end
      end else begin
         disc = b * b - 4 * a * c;
         two_a = 2 * a;
         nb = -b * 256;
         mag = (disc < 0) ? -disc : disc;
         s = int_sqrt(mag << 16);
         if (disc == 0) begin
            r.kind = KIND_DOUBLE;
            r.r0 = divide_clamp(nb * 256, two_a, r.sat);
            r.r1 = r.r0;
         end else if (disc > 0) begin
            r.kind = KIND_DISTINCT;
            r.r0 = divide_clamp((nb - s) * 256, two_a, r.sat);
            r.r1 = divide_clamp((nb + s) * 256, two_a, r.sat);
         end else begin
            r.kind = KIND_COMPLEX;
            r.r0 = divide_clamp(nb * 256, two_a, r.sat);
            r.r1 = divide_clamp(s * 256, two_a, r.sat);
         end
      end
      return r;
   endfunction

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd0;
         3: return $urandom_range(0, 3) == 0 ? -16'sd1 : 16'sd1;
         4, 5: return $signed(16'($urandom_range(0, 1023)) - 16'sd512);
         default: return $signed(16'($urandom));
      endcase
   endfunction

   task automatic add_set(int a, int b, int c);
      coef_set_type cs;
      cs.a = 16'(a);
      cs.b = 16'(b);
      cs.c = 16'(c);
      pending_sets.push_back(cs);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_roots.push_back(solve_quadratic({req_coef_a, req_coef_b, req_coef_c}));
            transfer_count++;
         end
         if ((start && busy) || (pending_sets.size() == 0 && !(start && !busy))) begin
         end else if (!hold_sender && pending_sets.size() != 0
                      && $urandom_range(0, 99) >= send_idle_pct) begin
            coef_set_type cs;
            cs = pending_sets.pop_front();
            start <= 1'b1;
            req_coef_a <= cs.a;
            req_coef_b <= cs.b;
            req_coef_c <= cs.c;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         root_set_type want;
         if (expected_roots.size() == 0) begin
            $display("%0t unexpected result kind %0d", $realtime, rsp_root_kind);
            error_count++;
         end else begin
            want = expected_roots.pop_front();
            if (rsp_root_kind !== want.kind) begin
               $display("%0t kind expected %0d actual %0d", $realtime, want.kind,
                        rsp_root_kind);
               error_count++;
            end
            if (rsp_first_root !== want.r0) begin
               $display("%0t first_root expected %0d actual %0d", $realtime, want.r0,
                        rsp_first_root);
               error_count++;
            end
            if (rsp_second_root !== want.r1) begin
               $display("%0t second_root expected %0d actual %0d", $realtime, want.r1,
                        rsp_second_root);
               error_count++;
            end
            if (rsp_saturated !== want.sat) begin
               $display("%0t saturated expected %0d actual %0d", $realtime, want.sat,
                        rsp_saturated);
               error_count++;
            end
            if (want.kind <= KIND_COMPLEX) kind_seen[want.kind]++;
            if (want.sat) sat_seen++;
         end
      end
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int k, b, a, c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      add_set(0, 0, 0);
      add_set(0, 0, 256);
      add_set(0, 0, -32768);
      add_set(0, 256, -512);
      add_set(0, 1, 32767);
      add_set(0, -1, -32768);
      add_set(0, 32767, 1);
      add_set(256, -512, 256);
      add_set(256, 0, 0);
      add_set(256, 0, -1024);
      add_set(256, -768, 512);
      add_set(256, 0, 256);
      add_set(256, 512, 1280);
      add_set(1, 32767, 0);
      add_set(1, -32768, -32768);
      add_set(-32768, -32768, -32768);
      add_set(32767, 32767, 32767);
      add_set(-32768, 0, 32767);
      add_set(-1, 0, -32768);
      add_set(32767, -32768, 1);
      add_set(-256, 512, 768);
      add_set(16'h5555, 16'haaaa, 16'h5555 - 65536);
      add_set(-1, -1, -1);
      while (pending_sets.size() != 0 || start) @(posedge clock);

      hold_sender = 1'b1;
      while (expected_roots.size() != 0) @(posedge clock);
      hold_sender = 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 57 : 0;
         for (int i = 0; i < 210; i++) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
               b = $signed(16'($urandom_range(0, 255) * 2)) - 256;
               a = $urandom_range(1, 64);
               c = (b * b) / (4 * a);
               if (c * 4 * a == b * b && c <= 32767) add_set(a, b, c);
               else add_set(pick_coef(), pick_coef(), pick_coef());
            end else if (k == 1) begin
               add_set(0, pick_coef(), pick_coef());
            end else begin
               add_set(pick_coef(), pick_coef(), pick_coef());
            end
         end
         while (pending_sets.size() != 0 || start) @(posedge clock);
      end

      while (expected_roots.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("Transfers %0d: indeterminate %0d impossible %0d linear %0d double %0d",
               transfer_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("distinct %0d complex %0d saturated %0d", kind_seen[4], kind_seen[5],
               sat_seen);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
